// File: design/assert_macros.svh
// Assertion macros used by the RTL core of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: design/swqt_pkg.sv
// Package with the constants, codes and types of the semaphore wait queue table.
package swqt_pkg;

    localparam int NUM_DESCRIPTORS = 32;
    localparam int DESC_W          = $clog2(NUM_DESCRIPTORS);
    localparam int PID_W           = 5;
    localparam int NUM_PROCESSES   = 2 ** PID_W;
    localparam int KEY_W           = 32;

    typedef enum logic {
        FN_BLOCK   = 1'b0,
        FN_RELEASE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_NO_FREE    = 2'd1,
        ST_NOT_ACTIVE = 2'd2,
        ST_NULL_KEY   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CLAIM,
        S_RDQ,
        S_HEAD,
        S_POP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic in_stall;
        logic scan_end;
        logic key_we;
        logic first_we;
        logic first_pid;
        logic last_we;
        logic succ_we;
        logic use_set;
        logic use_clr;
        logic pop;
        logic out_load;
    } t_ctl;

endpackage

// File: design/semaphore_wait_queue_table_core.sv
// Top level of the semaphore wait queue table: descriptor scan, queue memories and sequencer.
//
// One item at a time is in work. An item with a null key goes straight to the
// result; otherwise the descriptor scan reads the key memory through its single
// read port and compares one descriptor key per cycle, a full pass covering all
// 32 descriptors. Then come the queue memory reads and writes of S_CLAIM or of
// S_RDQ, S_HEAD and, for a release, S_POP, and S_DONE hands the result on.
// A result waiting in the output register does not keep the next item from
// being taken; it only holds back the delivery of the following result.
`include "assert_macros.svh"

module semaphore_wait_queue_table_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_func,
    input  logic [swqt_pkg::KEY_W-1:0]     i_sem_key,
    input  logic [swqt_pkg::PID_W-1:0]     i_proc_id,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_status,
    output logic [swqt_pkg::PID_W-1:0]     o_released_id,
    output logic                           o_released_valid
);

    localparam int DW = swqt_pkg::DESC_W;
    localparam int PW = swqt_pkg::PID_W;
    localparam int KW = swqt_pkg::KEY_W;

    swqt_pkg::t_state  r_state, n_state;
    swqt_pkg::t_ctl    ctl;
    swqt_pkg::t_func   r_func;
    swqt_pkg::t_status r_res_status;
    swqt_pkg::t_status r_out_status;

    logic [KW-1:0] r_key;
    logic [PW-1:0] r_pid;
    logic [DW:0]   r_idx;
    logic [DW-1:0] r_chk_idx;
    logic          r_chk_vld;
    logic [DW-1:0] r_free_idx;
    logic          r_free_found;
    logic [DW-1:0] r_desc;
    logic          hit;
    logic          scan_over;

    logic [swqt_pkg::NUM_DESCRIPTORS-1:0] r_in_use;

    logic [KW-1:0] r_mem_key   [swqt_pkg::NUM_DESCRIPTORS];
    logic [PW-1:0] r_mem_first [swqt_pkg::NUM_DESCRIPTORS];
    logic [PW-1:0] r_mem_last  [swqt_pkg::NUM_DESCRIPTORS];
    logic [PW-1:0] r_mem_succ  [swqt_pkg::NUM_PROCESSES];

    logic [KW-1:0] r_key_q;
    logic [PW-1:0] r_first_q;
    logic [PW-1:0] r_last_q;
    logic [PW-1:0] r_succ_q;

    logic [PW-1:0] r_res_id;
    logic          r_res_rvld;
    logic          r_out_vld;
    logic [PW-1:0] r_out_id;
    logic          r_out_rvld;

    assign hit = (r_state == swqt_pkg::S_SCAN) && r_chk_vld && r_in_use[r_chk_idx]
                 && (r_key_q == r_key);
    assign scan_over = (r_idx == (DW+1)'(swqt_pkg::NUM_DESCRIPTORS));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swqt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_sem_key == '0) ? swqt_pkg::S_DONE : swqt_pkg::S_SCAN;
                end
            end
            swqt_pkg::S_SCAN: begin
                if (hit) begin
                    n_state = swqt_pkg::S_RDQ;
                end else if (scan_over) begin
                    if (r_func == swqt_pkg::FN_BLOCK && r_free_found) begin
                        n_state = swqt_pkg::S_CLAIM;
                    end else begin
                        n_state = swqt_pkg::S_DONE;
                    end
                end
            end
            swqt_pkg::S_CLAIM: n_state = swqt_pkg::S_DONE;
            swqt_pkg::S_RDQ:   n_state = swqt_pkg::S_HEAD;
            swqt_pkg::S_HEAD: begin
                n_state = (r_func == swqt_pkg::FN_BLOCK) ? swqt_pkg::S_DONE : swqt_pkg::S_POP;
            end
            swqt_pkg::S_POP:   n_state = swqt_pkg::S_DONE;
            swqt_pkg::S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_state = swqt_pkg::S_IDLE;
                end
            end
            default: n_state = swqt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        ctl.in_stall = 1'b1;
        unique case (r_state)
            swqt_pkg::S_IDLE: ctl.in_stall = 1'b0;
            swqt_pkg::S_SCAN: ctl.scan_end = !hit && scan_over;
            swqt_pkg::S_CLAIM: begin
                ctl.key_we    = 1'b1;
                ctl.first_we  = 1'b1;
                ctl.first_pid = 1'b1;
                ctl.last_we   = 1'b1;
                ctl.use_set   = 1'b1;
            end
            swqt_pkg::S_RDQ: ctl.in_stall = 1'b1;
            swqt_pkg::S_HEAD: begin
                ctl.succ_we = (r_func == swqt_pkg::FN_BLOCK);
                ctl.last_we = (r_func == swqt_pkg::FN_BLOCK);
            end
            swqt_pkg::S_POP: begin
                ctl.pop      = 1'b1;
                ctl.use_clr  = (r_first_q == r_last_q);
                ctl.first_we = (r_first_q != r_last_q);
            end
            swqt_pkg::S_DONE: ctl.out_load = !r_out_vld || !i_out_stall;
            default: ctl.in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= swqt_pkg::S_IDLE;
            r_idx        <= '0;
            r_chk_vld    <= 1'b0;
            r_free_found <= 1'b0;
            r_in_use     <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == swqt_pkg::S_IDLE) begin
                r_idx        <= '0;
                r_chk_vld    <= 1'b0;
                r_free_found <= 1'b0;
            end else if (r_state == swqt_pkg::S_SCAN) begin
                r_chk_vld <= 1'b1;
                if (!scan_over) begin
                    r_idx <= r_idx + 1'b1;
                    if (!r_free_found && !r_in_use[r_idx[DW-1:0]]) begin
                        r_free_found <= 1'b1;
                    end
                end
            end
            if (ctl.use_set) begin
                r_in_use[r_desc] <= 1'b1;
            end
            if (ctl.use_clr) begin
                r_in_use[r_desc] <= 1'b0;
            end
            if (ctl.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !ctl.in_stall) begin
            r_func       <= swqt_pkg::t_func'(i_func);
            r_key        <= i_sem_key;
            r_pid        <= i_proc_id;
            r_res_status <= (i_sem_key == '0) ? swqt_pkg::ST_NULL_KEY : swqt_pkg::ST_DONE;
            r_res_id     <= '0;
            r_res_rvld   <= 1'b0;
        end
        r_chk_idx <= r_idx[DW-1:0];
        if (r_state == swqt_pkg::S_SCAN && !scan_over && !r_free_found
                && !r_in_use[r_idx[DW-1:0]]) begin
            r_free_idx <= r_idx[DW-1:0];
        end
        if (hit) begin
            r_desc <= r_chk_idx;
        end else if (ctl.scan_end) begin
            r_desc <= r_free_idx;
            if (r_func == swqt_pkg::FN_RELEASE) begin
                r_res_status <= swqt_pkg::ST_NOT_ACTIVE;
            end else if (!r_free_found) begin
                r_res_status <= swqt_pkg::ST_NO_FREE;
            end
        end
        if (ctl.pop) begin
            r_res_id   <= r_first_q;
            r_res_rvld <= 1'b1;
        end
        if (ctl.out_load) begin
            r_out_status <= r_res_status;
            r_out_id     <= r_res_id;
            r_out_rvld   <= r_res_rvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.key_we) begin
            r_mem_key[r_desc] <= r_key;
        end
        r_key_q <= r_mem_key[r_idx[DW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (ctl.first_we) begin
            r_mem_first[r_desc] <= ctl.first_pid ? r_pid : r_succ_q;
        end
        r_first_q <= r_mem_first[r_desc];
    end

    always_ff @(posedge i_clk) begin
        if (ctl.last_we) begin
            r_mem_last[r_desc] <= r_pid;
        end
        r_last_q <= r_mem_last[r_desc];
    end

    always_ff @(posedge i_clk) begin
        if (ctl.succ_we) begin
            r_mem_succ[r_last_q] <= r_pid;
        end
        r_succ_q <= r_mem_succ[r_first_q];
    end

    assign o_in_stall       = ctl.in_stall;
    assign o_out_valid      = r_out_vld;
    assign o_status         = r_out_status;
    assign o_released_id    = r_out_id;
    assign o_released_valid = r_out_rvld;

    `ASSERT_CLK(a_release_status, i_clk, i_rst_n, o_out_valid && o_released_valid |-> o_status == swqt_pkg::ST_DONE, "released process with a failing status")
    `ASSERT_CLK(a_claim_sets_use, i_clk, i_rst_n, ctl.use_set |=> r_in_use[$past(r_desc)], "claimed descriptor not marked in use")
    `ASSERT_CLK(a_scan_bound, i_clk, i_rst_n, r_state == swqt_pkg::S_SCAN |-> r_idx <= (DW+1)'(swqt_pkg::NUM_DESCRIPTORS), "scan index ran past the descriptor pool")
    `ASSERT_CLK(a_load_slot, i_clk, i_rst_n, ctl.out_load |-> !r_out_vld || !i_out_stall, "result loaded over a transfer still waiting")

endmodule
